[hdl/tbps_pkg.sv]
// Shared types and constants for the token bucket packet shaper.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package tbps_pkg;

    localparam int unsigned ID_W     = 16;
    localparam int unsigned TOKEN_W  = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned WAIT_W   = 7;
    localparam int unsigned ENTRY_W  = ID_W + TOKEN_W;

    localparam logic [TOKEN_W-1:0] BUCKET_DEPTH_RST = 16'd10;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_ARRIVAL = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_TOKEN_KEPT = 3'd0,
        ST_TOKEN_DROP = 3'd1,
        ST_TOO_BIG    = 3'd2,
        ST_QUEUED     = 3'd3,
        ST_PASSED     = 3'd4,
        ST_QFULL      = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load_in;  // capture input word, start head read
        logic exec;     // apply the step and load the output register
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_valid;
    } t_dp_stat;

endpackage

`default_nettype wire

[hdl/tbps_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tbps_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/tbps_ctrl.sv]
// Controller state machine of the shaper: sequences capture and execute.
// Depends on tbps_pkg.
`default_nettype none

module tbps_ctrl
    import tbps_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_s_tvalid,
    output logic           o_s_tready,
    input  wire logic      i_m_tready,
    input  wire t_dp_stat  i_stat,
    output t_ctrl_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        o_cmd.load_in = 1'b0;
        o_cmd.exec    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register is free or drains this cycle
                if (!i_stat.out_valid || i_m_tready) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/tbps_dp.sv]
// Datapath of the shaper: bucket, queue pointers, queue memory, output register.
// Depends on tbps_pkg and tbps_ram.
`default_nettype none

module tbps_dp
    import tbps_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_ctrl_cmd           i_cmd,
    output t_dp_stat                 o_stat,
    input  wire logic                i_opcode,
    input  wire logic [ID_W-1:0]     i_packet_id,
    input  wire logic [TOKEN_W-1:0]  i_tokens_needed,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [TOKEN_W-1:0]  i_cfg_wr_data,
    input  wire logic                i_m_tready,
    output logic                     o_out_valid,
    output logic [STATUS_W-1:0]      o_status,
    output logic                     o_release_valid,
    output logic [ID_W-1:0]          o_release_id,
    output logic [TOKEN_W-1:0]       o_tokens_now,
    output logic [WAIT_W-1:0]        o_waiting_now
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    // captured input word (payload, no reset)
    logic               r_op;
    logic [ID_W-1:0]    r_id;
    logic [TOKEN_W-1:0] r_need;

    logic [TOKEN_W-1:0] r_depth;
    logic [TOKEN_W-1:0] r_tokens;
    logic [TOKEN_W-1:0] n_tokens;
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   n_head;
    logic [PTR_W-1:0]   r_tail;
    logic [PTR_W-1:0]   n_tail;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   n_fill;

    logic               r_out_valid;
    t_status            r_status;
    t_status            n_status;
    logic               r_rel_valid;
    logic               n_rel_valid;
    logic [ID_W-1:0]    r_rel_id;
    logic [ID_W-1:0]    n_rel_id;

    logic [ENTRY_W-1:0] head_entry;
    logic [TOKEN_W-1:0] head_need;
    logic [TOKEN_W-1:0] tick_tokens;
    logic               enq;
    logic [31:0]        fill_wide;

    tbps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .i_clk     (i_clk),
        .i_wr_en   (enq),
        .i_wr_addr (r_tail),
        .i_wr_data ({r_id, r_need}),
        .i_rd_en   (i_cmd.load_in),
        .i_rd_addr (r_head),
        .o_rd_data (head_entry)
    );

    assign head_need = head_entry[TOKEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_opcode;
            r_id   <= i_packet_id;
            r_need <= i_tokens_needed;
        end
    end

    always_comb begin
        n_tokens    = r_tokens;
        n_head      = r_head;
        n_tail      = r_tail;
        n_fill      = r_fill;
        n_status    = ST_TOKEN_KEPT;
        n_rel_valid = 1'b0;
        n_rel_id    = '0;
        enq         = 1'b0;
        tick_tokens = r_tokens;
        if (r_op == OP_TICK) begin
            if (r_tokens >= r_depth) begin
                n_status = ST_TOKEN_DROP;
            end else begin
                tick_tokens = r_tokens + TOKEN_W'(1);
            end
            n_tokens = tick_tokens;
            if (r_fill != '0 && head_need <= tick_tokens) begin
                n_tokens    = tick_tokens - head_need;
                n_rel_valid = 1'b1;
                n_rel_id    = head_entry[ENTRY_W-1:TOKEN_W];
                n_head      = (r_head == LAST_SLOT) ? '0 : r_head + PTR_W'(1);
                n_fill      = r_fill - CNT_W'(1);
            end
        end else begin
            priority if (r_need > r_depth) begin
                n_status = ST_TOO_BIG;
            end else if (r_fill == '0 && r_need <= r_tokens) begin
                n_tokens    = r_tokens - r_need;
                n_status    = ST_PASSED;
                n_rel_valid = 1'b1;
                n_rel_id    = r_id;
            end else if (r_fill >= FULL_CNT) begin
                n_status = ST_QFULL;
            end else begin
                enq      = i_cmd.exec;
                n_tail   = (r_tail == LAST_SLOT) ? '0 : r_tail + PTR_W'(1);
                n_fill   = r_fill + CNT_W'(1);
                n_status = ST_QUEUED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= BUCKET_DEPTH_RST;
            r_tokens    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_depth <= i_cfg_wr_data;
            end
            if (i_cmd.exec) begin
                r_tokens    <= n_tokens;
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result fields are payload; tokens and fill are read from the state registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status    <= n_status;
            r_rel_valid <= n_rel_valid;
            r_rel_id    <= n_rel_id;
        end
    end

    assign fill_wide        = 32'(r_fill);
    assign o_stat.out_valid = r_out_valid;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_release_valid  = r_rel_valid;
    assign o_release_id     = r_rel_id;
    assign o_tokens_now     = r_tokens;
    assign o_waiting_now    = fill_wide[WAIT_W-1:0];

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("queue fill above depth");

    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || r_fill == FULL_CNT) |-> (r_head == r_tail))
        else $error("head and tail apart while queue empty or full");

    a_exec_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_out_valid || i_m_tready))
        else $error("step executed over an untaken result");

    a_exec_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("executed step left no result");
`endif

endmodule

`default_nettype wire

[hdl/token_bucket_packet_shaper_core.sv]
// Token bucket packet shaper, top level: stream ports, controller and datapath.
// Depends on tbps_pkg, tbps_ctrl, tbps_dp (which holds tbps_ram).
//
// Usage:
//   Input stream (s side): one word per event. tuser is the opcode
//   (0 token tick, 1 packet arrival); tdata carries packet_id and
//   tokens_needed, both ignored for ticks.
//   Output stream (m side): exactly one result word per input word, in order,
//   with status, release flag and id, bucket level and queue fill after the step.
//   Config: i_cfg_wr_en writes bucket_depth from i_cfg_wr_data at the clock
//   edge; write it only while the block is idle.
// Timing:
//   Each word passes a capture step (take the word, read the queue head from
//   the queue RAM, registered read) and an execute step (update bucket and
//   queue, load the result register); no word is taken before the last one's
//   execute step. A result waiting on the m side does not block the next acceptance; the
//   execute cycle of that next word holds until the result register drains.
// Reset:
//   Synchronous, active low. Clears bucket level, queue pointers and fill,
//   sets bucket_depth to 10. Queue RAM contents are not cleared; no wait.
`default_nettype none

module token_bucket_packet_shaper_core
    import tbps_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // slave side: input words
    input  wire logic               i_s_tvalid,
    output logic                    o_s_tready,
    input  wire logic [31:0]        i_s_tdata,   // [15:0] packet_id, [31:16] tokens_needed
    input  wire logic               i_s_tuser,   // [0] opcode
    // master side: result words
    output logic                    o_m_tvalid,
    input  wire logic               i_m_tready,
    output logic [39:0]             o_m_tdata,   // [15:0] release_id, [31:16] tokens_now,
                                                 // [38:32] waiting_now, [39] zero
    output logic [3:0]              o_m_tuser,   // [2:0] status, [3] release_valid
    // bucket_depth register
    input  wire logic               i_cfg_wr_en,
    input  wire logic [TOKEN_W-1:0] i_cfg_wr_data
);

    t_ctrl_cmd          cmd;
    t_dp_stat           stat;
    logic [STATUS_W-1:0] status;
    logic               release_valid;
    logic [ID_W-1:0]    release_id;
    logic [TOKEN_W-1:0] tokens_now;
    logic [WAIT_W-1:0]  waiting_now;

    // sequence capture and execute; hold execute while the result waits
    tbps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_m_tready (i_m_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // bucket, queue and result register
    tbps_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_s_tuser),
        .i_packet_id     (i_s_tdata[15:0]),
        .i_tokens_needed (i_s_tdata[31:16]),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_m_tready      (i_m_tready),
        .o_out_valid     (o_m_tvalid),
        .o_status        (status),
        .o_release_valid (release_valid),
        .o_release_id    (release_id),
        .o_tokens_now    (tokens_now),
        .o_waiting_now   (waiting_now)
    );

    // pack the result word; pad tdata to whole bytes
    assign o_m_tdata = {1'b0, waiting_now, tokens_now, release_id};
    assign o_m_tuser = {release_valid, status};

endmodule

`default_nettype wire
